[rtl/pdir_pkg.sv]
`timescale 1ns / 1ps
package pdir_pkg;

   localparam int SLOT_W = 6;
   localparam int LIVE_W = 7;

   localparam logic CSR_OWN_KEY = 1'b0;
   localparam logic CSR_TTL_MS  = 1'b1;

   typedef enum logic [1:0] {
      OP_MANIFEST = 2'd0,
      OP_ROUTE    = 2'd1,
      OP_GC       = 2'd2,
      OP_FUSE     = 2'd3
   } pdir_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } pdir_state_type;

   typedef struct packed {
      pdir_op_type op;
      logic [63:0] key;
      logic [31:0] caps;
      logic [15:0] dom;
      logic [31:0] now;
      logic [31:0] digest;
      logic [31:0] ttl;
   } pdir_query_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
      logic [63:0]       key;
      logic [31:0]       caps;
      logic [15:0]       free;
      logic              busy;
      logic [31:0]       digest;
      logic [15:0]       dom;
      logic [31:0]       seen;
   } pdir_write_type;

   typedef struct packed {
      logic              token;
      logic              match_hit;
      logic [SLOT_W-1:0] match_idx;
      logic              free_hit;
      logic [SLOT_W-1:0] free_idx;
      logic              old_hit;
      logic [SLOT_W-1:0] old_idx;
      logic [31:0]       old_seen;
      logic              best_hit;
      logic [15:0]       best_free;
      logic [63:0]       best_key;
      logic [LIVE_W-1:0] live;
      logic              fuse_ok;
   } pdir_carry_type;

endpackage

[rtl/peer_capability_directory.sv]
`timescale 1ns / 1ps
// channel | direction | transfer when
// req_    | in        | req_valid && req_ready
// rsp_    | out       | rsp_valid && rsp_ready
// csr_    | in        | csr_valid && csr_ready (always ready)
// For each item a query token walks the chain of slot cells one cell per cycle,
// then the result is formed and any slot written.
// One item is in flight; req_ready is high only while idle.
// A fuse item that is not the last of its batch gives no response.
// Reset clears all slot valid bits, the fuse state, the control state and rsp_valid; it sets own key 0, TTL 10000.
// A held response stalls only the final step of the next item.
module peer_capability_directory
   import pdir_pkg::*;
#(
   parameter int PEER_SLOTS  = 16,
   parameter int KEY_BYTES   = 8,
   parameter int DOMAIN_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [63:0]       req_peer_key,
   input  logic [31:0]       req_caps,
   input  logic [15:0]       req_free_kb,
   input  logic              req_busy_req,
   input  logic [31:0]       req_digest,
   input  logic [15:0]       req_domain_mask,
   input  logic [31:0]       req_now_ms,
   input  logic [7:0]        req_confidence,
   input  logic [7:0]        req_min_confidence,
   input  logic              req_last_candidate,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_hit,
   output logic [63:0]       rsp_chosen_key,
   output logic signed [8:0] rsp_candidate_index,
   output logic [6:0]        rsp_live_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [63:0]       csr_wdata
);

   localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);
   localparam logic [15:0] DOM_KEEP =
      (DOMAIN_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DOMAIN_BITS) - 32'd1);

   pdir_state_type state_ff, state_in;
   pdir_query_type query_ff;
   logic [15:0]    free_ff;
   logic           busy_ff;
   logic [7:0]     conf_ff;
   logic [7:0]     minc_ff;
   logic           last_ff;
   logic [63:0]    own_key_ff;
   logic [31:0]    ttl_ff;
   logic           inject_ff;
   pdir_carry_type tail_ff;
   pdir_carry_type chain [0:PEER_SLOTS];
   pdir_write_type wr;

   logic           fuse_have_ff;
   logic [8:0]     fuse_idx_ff;
   logic [7:0]     fuse_conf_ff;
   logic [63:0]    fuse_key_ff;
   logic [7:0]     fuse_pos_ff;

   logic           rsp_valid_ff;
   logic           rsp_hit_ff;
   logic [63:0]    rsp_key_ff;
   logic [8:0]     rsp_idx_ff;
   logic [6:0]     rsp_live_ff;

   logic           finish;
   logic           reject;
   logic           fuse_take;
   logic           fuse_have_nx;
   logic [63:0]    fuse_key_nx;
   logic [8:0]     fuse_idx_nx;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign finish    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign chain[0] = '{token: inject_ff, default: '0};

   for (genvar g = 0; g < PEER_SLOTS; g++) begin : g_cell
      pdir_cell #(
         .CELL_ID  (g),
         .DOM_KEEP (DOM_KEEP)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .query     (query_ff),
         .wr        (wr),
         .carry_in  (chain[g]),
         .carry_out (chain[g+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_SCAN;
         ST_SCAN: if (chain[PEER_SLOTS].token) state_in = ST_DONE;
         ST_DONE: if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      reject    = (query_ff.key == 64'd0) || (query_ff.key == (own_key_ff & KEY_MASK));
      wr        = '0;
      wr.key    = query_ff.key;
      wr.caps   = query_ff.caps;
      wr.free   = free_ff;
      wr.busy   = busy_ff;
      wr.digest = query_ff.digest;
      wr.dom    = query_ff.dom;
      wr.seen   = query_ff.now;
      wr.en     = finish && query_ff.op == OP_MANIFEST && !reject;
      if (tail_ff.match_hit) begin
         wr.idx = tail_ff.match_idx;
      end else if (tail_ff.free_hit) begin
         wr.idx = tail_ff.free_idx;
      end else begin
         wr.idx = tail_ff.old_idx;
      end
      fuse_take = tail_ff.match_hit && tail_ff.fuse_ok && query_ff.key != 64'd0
               && conf_ff >= minc_ff
               && (!fuse_have_ff || conf_ff > fuse_conf_ff
                   || (conf_ff == fuse_conf_ff && query_ff.key < fuse_key_ff));
      fuse_have_nx = fuse_have_ff || fuse_take;
      fuse_key_nx  = fuse_take ? query_ff.key : fuse_key_ff;
      fuse_idx_nx  = fuse_take ? {1'b0, fuse_pos_ff} : fuse_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inject_ff    <= 1'b0;
         own_key_ff   <= 64'd0;
         ttl_ff       <= 32'd10000;
         fuse_have_ff <= 1'b0;
         fuse_idx_ff  <= '1;
         fuse_conf_ff <= 8'd0;
         fuse_key_ff  <= 64'd0;
         fuse_pos_ff  <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         inject_ff <= req_valid && req_ready;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_OWN_KEY: own_key_ff <= csr_wdata;
               CSR_TTL_MS:  ttl_ff     <= csr_wdata[31:0];
               default:     ;
            endcase
         end
         if (finish && (query_ff.op != OP_FUSE || last_ff)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (finish && query_ff.op == OP_FUSE) begin
            if (last_ff) begin
               fuse_have_ff <= 1'b0;
               fuse_idx_ff  <= '1;
               fuse_conf_ff <= 8'd0;
               fuse_key_ff  <= 64'd0;
               fuse_pos_ff  <= 8'd0;
            end else begin
               fuse_have_ff <= fuse_have_nx;
               fuse_idx_ff  <= fuse_idx_nx;
               fuse_key_ff  <= fuse_key_nx;
               fuse_pos_ff  <= fuse_pos_ff + 8'd1;
               if (fuse_take) fuse_conf_ff <= conf_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         query_ff.op     <= pdir_op_type'(req_op);
         query_ff.key    <= req_peer_key & KEY_MASK;
         query_ff.caps   <= req_caps;
         query_ff.dom    <= req_domain_mask;
         query_ff.now    <= req_now_ms;
         query_ff.digest <= req_digest;
         query_ff.ttl    <= ttl_ff;
         free_ff         <= req_free_kb;
         busy_ff         <= req_busy_req;
         conf_ff         <= req_confidence;
         minc_ff         <= req_min_confidence;
         last_ff         <= req_last_candidate;
      end
      if (chain[PEER_SLOTS].token) begin
         tail_ff <= chain[PEER_SLOTS];
      end
      if (finish) begin
         unique case (query_ff.op)
            OP_MANIFEST: begin
               rsp_hit_ff  <= !reject;
               rsp_key_ff  <= reject ? 64'd0 : query_ff.key;
               rsp_idx_ff  <= '1;
               rsp_live_ff <= 7'd0;
            end
            OP_ROUTE: begin
               rsp_hit_ff  <= tail_ff.best_hit;
               rsp_key_ff  <= tail_ff.best_hit ? tail_ff.best_key : 64'd0;
               rsp_idx_ff  <= '1;
               rsp_live_ff <= 7'd0;
            end
            OP_GC: begin
               rsp_hit_ff  <= 1'b0;
               rsp_key_ff  <= 64'd0;
               rsp_idx_ff  <= '1;
               rsp_live_ff <= tail_ff.live;
            end
            OP_FUSE: begin
               rsp_hit_ff  <= fuse_have_nx;
               rsp_key_ff  <= fuse_have_nx ? fuse_key_nx : 64'd0;
               rsp_idx_ff  <= fuse_have_nx ? fuse_idx_nx : '1;
               rsp_live_ff <= 7'd0;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_chosen_key      = rsp_key_ff;
   assign rsp_candidate_index = $signed(rsp_idx_ff);
   assign rsp_live_count      = rsp_live_ff;

   a_write_at_end: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> state_ff == ST_DONE)
      else $error("slot written outside final step");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[PEER_SLOTS].token |-> state_ff == ST_SCAN)
      else $error("chain token left outside scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside final step");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !inject_ff)
      else $error("token injected while idle");

endmodule

[rtl/pdir_cell.sv]
`timescale 1ns / 1ps
module pdir_cell
   import pdir_pkg::*;
#(
   parameter int          CELL_ID  = 0,
   parameter logic [15:0] DOM_KEEP = 16'hFFFF
) (
   input  logic           clock,
   input  logic           reset,
   input  pdir_query_type query,
   input  pdir_write_type wr,
   input  pdir_carry_type carry_in,
   output pdir_carry_type carry_out
);

   logic           valid_ff;
   logic [63:0]    key_ff;
   logic [31:0]    caps_ff;
   logic [15:0]    free_ff;
   logic           busy_ff;
   logic [31:0]    digest_ff;
   logic [15:0]    dom_ff;
   logic [31:0]    seen_ff;
   pdir_carry_type carry_ff;
   pdir_carry_type carry_in_nx;
   logic [31:0]    age;
   logic           stale;
   logic           usable;
   logic           key_eq;

   always_comb begin
      age    = (query.now >= seen_ff) ? (query.now - seen_ff) : 32'd0;
      stale  = age > query.ttl;
      key_eq = valid_ff && (key_ff == query.key);
      usable = valid_ff && !busy_ff && !stale
            && ((query.caps == 32'd0) || ((caps_ff & query.caps) != 32'd0))
            && ((dom_ff & query.dom) == query.dom);
      carry_in_nx = carry_in;
      if (key_eq && !carry_in.match_hit) begin
         carry_in_nx.match_hit = 1'b1;
         carry_in_nx.match_idx = SLOT_W'(CELL_ID);
         carry_in_nx.fuse_ok   = !stale && (digest_ff == query.digest);
      end
      if (!valid_ff && !carry_in.free_hit) begin
         carry_in_nx.free_hit = 1'b1;
         carry_in_nx.free_idx = SLOT_W'(CELL_ID);
      end
      if (valid_ff && (!carry_in.old_hit || seen_ff < carry_in.old_seen)) begin
         carry_in_nx.old_hit  = 1'b1;
         carry_in_nx.old_idx  = SLOT_W'(CELL_ID);
         carry_in_nx.old_seen = seen_ff;
      end
      if (usable && (!carry_in.best_hit || free_ff > carry_in.best_free
            || (free_ff == carry_in.best_free && key_ff < carry_in.best_key))) begin
         carry_in_nx.best_hit  = 1'b1;
         carry_in_nx.best_free = free_ff;
         carry_in_nx.best_key  = key_ff;
      end
      if (valid_ff && !stale) begin
         carry_in_nx.live = carry_in.live + LIVE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in.token ? carry_in_nx : '0;
         if (wr.en && wr.idx == SLOT_W'(CELL_ID)) begin
            valid_ff <= 1'b1;
         end else if (carry_in.token && query.op == OP_GC && valid_ff && stale) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.idx == SLOT_W'(CELL_ID)) begin
         key_ff    <= wr.key;
         caps_ff   <= wr.caps;
         free_ff   <= wr.free;
         busy_ff   <= wr.busy;
         digest_ff <= wr.digest;
         dom_ff    <= wr.dom & DOM_KEEP;
         seen_ff   <= wr.seen;
      end
   end

   assign carry_out = carry_ff;

endmodule
